@@ rtl/baro_temp_pressure_compensation_macros.svh @@
// Assertion helpers
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BTPC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define BTPC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/btpc_pkg.sv @@
package btpc_pkg;
  localparam int DivBits = 32;
  localparam int NumStages = 11 + DivBits;
  localparam logic [31:0] FineOffset = 32'd64000;
  localparam logic [31:0] PressBase = 32'd1048576;
  localparam logic [31:0] PressScale = 32'd3125;
  localparam logic [31:0] Half15 = 32'd32768;
  localparam logic [31:0] RoundTemp = 32'd128;
  localparam logic [17:0] PressMax = 18'h3FFFF;

  typedef enum logic [1:0] {
    CFG_TEMP = 2'd0,
    CFG_PRESS_LO = 2'd1,
    CFG_PRESS_HI = 2'd2,
    CFG_PRESS_NINE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] n;
    logic [31:0] d;
    logic [31:0] q;
    logic [31:0] r;
    logic        dbl;
    logic        err;
    logic [15:0] temp;
  } div_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[31:0];
  endfunction
endpackage

@@ rtl/baro_temp_pressure_compensation.sv @@
// Compensates a raw temperature/pressure pair into 0.01 degC and pascals with
// the standard 32-bit integer formulas. Fully pipelined: one item per cycle
// while not stalled, through seven front stages, a divider load stage, 32 divider
// stages of the restoring divider (one quotient bit each) and three back
// stages including the output register. A stall freezes the whole pipeline.
// Calibration writes must happen while the pipeline is empty.
`include "baro_temp_pressure_compensation_macros.svh"
module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_centi,
  output logic [17:0]        out_pressure_pa,
  output logic               out_status
);
  logic [47:0] temp_cal_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0; plo_r <= '0; phi_r <= '0; p9_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP:       temp_cal_r <= cfg_data[47:0];
        CFG_PRESS_LO:   plo_r <= cfg_data;
        CFG_PRESS_HI:   phi_r <= cfg_data;
        CFG_PRESS_NINE: p9_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_cal_r[15:0]};
  assign t2 = sx16(temp_cal_r[31:16]);
  assign t3 = sx16(temp_cal_r[47:32]);
  assign p1 = {16'd0, plo_r[15:0]};
  assign p2 = sx16(plo_r[31:16]);
  assign p3 = sx16(plo_r[47:32]);
  assign p4 = sx16(plo_r[63:48]);
  assign p5 = sx16(phi_r[15:0]);
  assign p6 = sx16(phi_r[31:16]);
  assign p7 = sx16(phi_r[47:32]);
  assign p8 = sx16(phi_r[63:48]);
  assign p9 = sx16(p9_r);

  logic en;
  logic [NumStages-1:0] v_r;
  assign en = !v_r[NumStages-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[NumStages-2:0], in_valid};
  end

  // front stages
  logic [31:0] s1_a_r, s1_b_r, s1_adcp_r;
  logic [31:0] s2_v1_r, s2_bb_r, s2_adcp_r;
  logic [31:0] s3_tf_r, s3_adcp_r;
  logic [31:0] s4_t_r, s4_sq_r, s4_adcp_r, s4_p2v_r, s4_p5v_r;
  logic [15:0] s5_temp_r;
  logic [31:0] s5_v2_r, s5_p3_r, s5_p2v_r, s5_adcp_r;
  logic [15:0] s6_temp_r;
  logic [31:0] s6_v1_r, s6_x_r;
  logic [15:0] s7_temp_r;
  logic [31:0] s7_v1_r, s7_n_r;
  logic [31:0] s3_tmp, s4_tv, s5_v2, s6_v1, s6_x, t_raw, bbt3;
  logic [15:0] t_sat;

  assign bbt3 = mul(asr(s2_bb_r, 12), t3);
  assign s3_tmp = s2_v1_r + asr(bbt3, 14);
  assign s4_tv = asr(s3_tf_r, 1) - FineOffset;
  assign t_raw = asr(s4_t_r, 8);
  assign t_sat = ($signed(t_raw) > 32'sd32767) ? 16'h7FFF :
                 ($signed(t_raw) < -32'sd32768) ? 16'h8000 : t_raw[15:0];
  assign s5_v2 = asr(mul(asr(s4_sq_r, 11), p6) + (s4_p5v_r << 1), 2) + (p4 << 16);
  assign s6_v1 = asr(asr(s5_p3_r, 3) + asr(s5_p2v_r, 1), 18);
  assign s6_x = (PressBase - s5_adcp_r) - asr(s5_v2_r, 12);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r <= {15'd0, in_raw_temperature[19:3]} - (t1 << 1);
      s1_b_r <= {16'd0, in_raw_temperature[19:4]} - t1;
      s1_adcp_r <= {12'd0, in_raw_pressure};
      s2_v1_r <= asr(mul(s1_a_r, t2), 11);
      s2_bb_r <= mul(s1_b_r, s1_b_r);
      s2_adcp_r <= s1_adcp_r;
      s3_tf_r <= s3_tmp;
      s3_adcp_r <= s2_adcp_r;
      s4_t_r <= mul(s3_tf_r, 32'd5) + RoundTemp;
      s4_sq_r <= mul(asr(s4_tv, 2), asr(s4_tv, 2));
      s4_p2v_r <= mul(p2, s4_tv);
      s4_p5v_r <= mul(s4_tv, p5);
      s4_adcp_r <= s3_adcp_r;
      s5_temp_r <= t_sat;
      s5_v2_r <= s5_v2;
      s5_p3_r <= mul(p3, asr(s4_sq_r, 13));
      s5_p2v_r <= s4_p2v_r;
      s5_adcp_r <= s4_adcp_r;
      s6_temp_r <= s5_temp_r;
      s6_v1_r <= s6_v1;
      s6_x_r <= s6_x;
      s7_temp_r <= s6_temp_r;
      s7_v1_r <= asr(mul(Half15 + s6_v1_r, p1), 15);
      s7_n_r <= mul(s6_x_r, PressScale);
    end
  end

  // restoring divider, one quotient bit per stage
  div_t d_r [DivBits+1];
  div_t d_nxt [DivBits];
  logic [32:0] d_rem [DivBits];
  logic [DivBits-1:0] d_ge;

  always_comb begin
    for (int i = 0; i < DivBits; i++) begin
      d_rem[i] = {d_r[i].r, d_r[i].n[DivBits-1-i]};
      d_ge[i] = d_rem[i] >= {1'b0, d_r[i].d};
      d_nxt[i] = d_r[i];
      d_nxt[i].r = d_ge[i] ? 32'(d_rem[i] - {1'b0, d_r[i].d}) : d_rem[i][31:0];
      d_nxt[i].q[DivBits-1-i] = d_ge[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= '{n: (s7_n_r[31] ? s7_n_r : (s7_n_r << 1)),
                  d: s7_v1_r,
                  q: 32'd0,
                  r: 32'd0,
                  dbl: s7_n_r[31],
                  err: (s7_v1_r == '0),
                  temp: s7_temp_r};
      for (int i = 0; i < DivBits; i++) d_r[i+1] <= d_nxt[i];
    end
  end

  logic [31:0] pq;
  assign pq = d_r[DivBits].dbl ? (d_r[DivBits].q << 1) : d_r[DivBits].q;

  // post stages
  logic [31:0] e1_p_r, e1_qq_r, e1_w2_r;
  logic [15:0] e1_temp_r, e2_temp_r;
  logic        e1_err_r, e2_err_r;
  logic [31:0] e2_p_r, e2_w1_r, e2_w2_r, e3_fin;
  logic [31:0] e1_q;
  logic [17:0] e2_sat;
  assign e1_q = pq >> 3;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_p_r <= pq;
      e1_qq_r <= mul(e1_q, e1_q) >> 13;
      e1_w2_r <= asr(mul(pq >> 2, p8), 13);
      e1_temp_r <= d_r[DivBits].temp;
      e1_err_r <= d_r[DivBits].err;
      e2_p_r <= e1_p_r;
      e2_w1_r <= asr(mul(p9, e1_qq_r), 12);
      e2_w2_r <= e1_w2_r;
      e2_temp_r <= e1_temp_r;
      e2_err_r <= e1_err_r;
    end
  end

  assign e3_fin = e2_p_r + asr(e2_w1_r + e2_w2_r + p7, 4);
  assign e2_sat = e3_fin[31] ? 18'd0 : (e3_fin > 32'(PressMax)) ? PressMax : e3_fin[17:0];

  always_ff @(posedge clk) begin
    if (en) begin
      out_temperature_centi <= e2_temp_r;
      out_pressure_pa <= e2_err_r ? 18'd0 : e2_sat;
      out_status <= e2_err_r;
    end
  end
  assign out_valid = v_r[NumStages-1];

  `BTPC_ASSERT_IMP(a_stall_ready, clk, rst_n, out_valid && !out_ready, !in_ready)
  `BTPC_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_pressure_pa) && $stable(out_status))
  `BTPC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status, out_pressure_pa == 18'd0)
endmodule

@@ tb/baro_temp_pressure_compensation_tb.sv @@
`timescale 1ns / 100ps
module baro_temp_pressure_compensation_tb;
  import btpc_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic [17:0]        press_pa;
    logic               status;
  } reading_t;

  class comp_scoreboard;
    logic [47:0] temp_cal;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_nine;
    reading_t    pending[$];
    int          errors;
    int          checked;

    function new();
      temp_cal = '0;
      press_lo = '0;
      press_hi = '0;
      press_nine = '0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
    endfunction

    function logic [31:0] m32(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[31:0];
    endfunction

    function reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, v1, v2, tf, q, sq, p, w1, w2, tr;
      reading_t r;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = sext(temp_cal[31:16]);
      t3 = sext(temp_cal[47:32]);
      p1 = {16'd0, press_lo[15:0]};
      p2 = sext(press_lo[31:16]);
      p3 = sext(press_lo[47:32]);
      p4 = sext(press_lo[63:48]);
      p5 = sext(press_hi[15:0]);
      p6 = sext(press_hi[31:16]);
      p7 = sext(press_hi[47:32]);
      p8 = sext(press_hi[63:48]);
      p9 = sext(press_nine);
      a = {12'd0, adc_t} >> 3;
      a = a - (t1 << 1);
      v1 = sra(m32(a, t2), 11);
      b = ({12'd0, adc_t} >> 4) - t1;
      v2 = sra(m32(sra(m32(b, b), 12), t3), 14);
      tf = v1 + v2;
      tr = sra(m32(tf, 32'd5) + 32'd128, 8);
      if ($signed(tr) > 32767) r.temp_centi = 16'sd32767;
      else if ($signed(tr) < -32768) r.temp_centi = 16'sh8000;
      else r.temp_centi = tr[15:0];
      v1 = sra(tf, 1) - 32'd64000;
      q = sra(v1, 2);
      sq = m32(q, q);
      v2 = m32(sra(sq, 11), p6);
      v2 = v2 + (m32(v1, p5) << 1);
      v2 = sra(v2, 2) + (p4 << 16);
      v1 = sra(sra(m32(p3, sra(sq, 13)), 3) + sra(m32(p2, v1), 1), 18);
      v1 = sra(m32(32'd32768 + v1, p1), 15);
      r.press_pa = '0;
      r.status = 1'b0;
      if (v1 == 0) begin
        r.status = 1'b1;
      end else begin
        p = m32((32'd1048576 - {12'd0, adc_p}) - sra(v2, 12), 32'd3125);
        if (p < 32'h80000000) p = (p << 1) / v1;
        else p = (p / v1) * 32'd2;
        q = p >> 3;
        w1 = sra(m32(p9, m32(q, q) >> 13), 12);
        w2 = sra(m32(p >> 2, p8), 13);
        p = p + sra(w1 + w2 + p7, 4);
        if ($signed(p) < 0) r.press_pa = '0;
        else if (p > 32'd262143) r.press_pa = 18'h3FFFF;
        else r.press_pa = p[17:0];
      end
      return r;
    endfunction

    function void note_input(logic [19:0] adc_t, logic [19:0] adc_p);
      pending.push_back(compensate(adc_t, adc_p));
    endfunction

    function void check_result(reading_t got);
      reading_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result t=%0d p=%0d s=%0d", $time,
                 got.temp_centi, got.press_pa, got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.temp_centi !== exp_r.temp_centi) begin
        $display("%0t: temperature exp %0d got %0d", $time, exp_r.temp_centi,
                 got.temp_centi);
        errors++;
      end
      if (got.press_pa !== exp_r.press_pa) begin
        $display("%0t: pressure exp %0d got %0d", $time, exp_r.press_pa, got.press_pa);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready;
  logic [19:0] in_raw_temperature, in_raw_pressure;
  logic out_valid, out_ready;
  logic signed [15:0] out_temperature_centi;
  logic [17:0] out_pressure_pa;
  logic out_status;

  comp_scoreboard sb;
  bit long_hold;
  int sent;

  baro_temp_pressure_compensation u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_temperature(in_raw_temperature), .in_raw_pressure(in_raw_pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_pa(out_pressure_pa), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_cal(cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TEMP: sb.temp_cal = val[47:0];
      CFG_PRESS_LO: sb.press_lo = val;
      CFG_PRESS_HI: sb.press_hi = val;
      default: sb.press_nine = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic [19:0] adc_t, logic [19:0] adc_p, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= adc_t;
    in_raw_pressure <= adc_p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(adc_t, adc_p);
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (NumStages + 10) @(posedge clk);
  endtask

  task automatic load_set(int kind);
    case (kind)
      0: begin
        write_cal(CFG_TEMP, 64'h0000_0032_6A27_6EBA);
        write_cal(CFG_PRESS_LO, 64'h0AFB_0BD0_D5D0_8E68);
        write_cal(CFG_PRESS_HI, 64'h0D4B_FFF9_FFF9_0027);
        write_cal(CFG_PRESS_NINE, 64'h0000_0000_0000_1770);
      end
      1: begin
        write_cal(CFG_TEMP, 64'h0000_7FFF_7FFF_FFFF);
        write_cal(CFG_PRESS_LO, 64'h7FFF_7FFF_7FFF_FFFF);
        write_cal(CFG_PRESS_HI, 64'h7FFF_7FFF_7FFF_7FFF);
        write_cal(CFG_PRESS_NINE, 64'h0000_0000_0000_7FFF);
      end
      2: begin
        write_cal(CFG_TEMP, 64'h0000_8000_8000_0000);
        write_cal(CFG_PRESS_LO, 64'h8000_8000_8000_0001);
        write_cal(CFG_PRESS_HI, 64'h8000_8000_8000_8000);
        write_cal(CFG_PRESS_NINE, 64'h0000_0000_0000_8000);
      end
      3: begin
        write_cal(CFG_PRESS_LO, 64'h0);
      end
      default: begin
        write_cal(CFG_TEMP, {$urandom, $urandom});
        write_cal(CFG_PRESS_LO, {$urandom, $urandom});
        write_cal(CFG_PRESS_HI, {$urandom, $urandom});
        write_cal(CFG_PRESS_NINE, {$urandom, $urandom});
      end
    endcase
  endtask

  // result side: random stalls, plus one long hold-off
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result('{out_temperature_centi, out_pressure_pa, out_status});
    end
  end

  initial begin
    logic [19:0] dt[6];
    int ph, k;
    sb = new();
    sent = 0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TEMP;
    cfg_data = '0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // all-zero calibration: zero divisor
    send_item(20'h0, 20'h0, 0);
    send_item(20'hFFFFF, 20'hFFFFF, 0);
    drain();
    load_set(0);
    dt = '{20'h0, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h82000, 20'h55555};
    foreach (dt[i]) send_item(dt[i], dt[5 - i], 0);
    send_item(20'h82000, 20'h50000, 0);
    send_item(20'h82000, 20'hAAAAA, 1);
    drain();
    for (ph = 1; ph <= 3; ph++) begin
      load_set(ph);
      foreach (dt[i]) send_item(dt[i], dt[i] ^ 20'hFFFFF, 1);
      drain();
    end
    // random phases; long receiver hold-off during the first one
    for (ph = 0; ph < 10; ph++) begin
      load_set(ph == 0 ? 0 : 4 + (ph % 3 == 0 ? 0 : 1) - 1 + 1);
      if (ph == 0) long_hold = 1'b1;
      for (k = 0; k < 100; k++)
        send_item(20'($urandom_range(0, 20'hFFFFF)),
                  ($urandom_range(0, 1) != 0) ? 20'($urandom_range(20'h40000, 20'h70000))
                                              : 20'($urandom_range(0, 20'hFFFFF)),
                  k % 25 >= 10);
      drain();
    end
    $display("Drove %0d items, checked %0d results over 14 calibration sets", sent,
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/btpc_pkg.sv
rtl/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_tb.sv
